>>> design/pemn_pkg.sv
// ----------------------------------------------------------------------------
// pemn_pkg
// Shared constants and types for the pad edge to MIDI note converter.
// ----------------------------------------------------------------------------
package pemn_pkg;

  localparam int NUM_PADS     = 6;
  localparam int PACKET_BYTES = 8;
  localparam int BYTE_W       = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;

  localparam int NOTE_W   = 7;
  localparam int GROUP_W  = 8;
  localparam int PAD_W    = 3;
  localparam int STATUS_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int PACKET_W   = 8 * PACKET_BYTES;

  localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE = 3'd6;

  localparam logic [STATUS_W-1:0] ST_ON     = 8'h99;
  localparam logic [STATUS_W-1:0] ST_OFF    = 8'h89;
  localparam logic [NOTE_W-1:0]   VEL_ON    = 7'h7F;
  localparam logic [NOTE_W-1:0]   VEL_OFF   = 7'h00;
  localparam logic [NOTE_W-1:0]   NOTE_BASE = 7'h20;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_GATHER = 3'b010,
    S_SCAN   = 3'b100
  } state_t;

endpackage

>>> design/pad_edge_to_midi_notes.sv
// ----------------------------------------------------------------------------
// pad_edge_to_midi_notes
// ORs pad report packets over a group, then scans the pads one per cycle
// (held while output stalls), sending a note-on or note-off per changed pad.
// ----------------------------------------------------------------------------
// Flow: a packet is registered on input, then its PACKET_BYTES (8) bytes
// pass one by one through the shared byte OR unit; at a group end the
// NUM_PADS (6) pads are scanned, one event per cycle while not stalled.
// in_stall holds off a new packet until the last one and any scan are done.
// Reset: synchronous; all pads held, note map 32..37, group size 0.
module pad_edge_to_midi_notes (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pemn_pkg::PACKET_W-1:0]       packet,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pemn_pkg::STATUS_W-1:0]       status_byte,
  output logic [pemn_pkg::NOTE_W-1:0]         note,
  output logic [pemn_pkg::NOTE_W-1:0]         velocity,
  output logic [pemn_pkg::PAD_W-1:0]          pad_index,
  output logic                                last_event,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pemn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pemn_pkg::CFG_DATA_W-1:0]     cfg_data
);

  pemn_pkg::state_t state;
  logic [pemn_pkg::PACKET_W-1:0] pkt;
  logic [pemn_pkg::BYTE_W-1:0]   byte_left;
  logic [pemn_pkg::NUM_PADS-1:0] acc;
  logic [pemn_pkg::NUM_PADS-1:0] acc_next;
  logic [pemn_pkg::NUM_PADS-1:0] held;
  logic [pemn_pkg::NUM_PADS-1:0] pads;
  logic [pemn_pkg::NUM_PADS-1:0] chg;
  logic [pemn_pkg::GROUP_W-1:0]  packet_counter;
  logic [pemn_pkg::GROUP_W-1:0]  group_size;
  logic [pemn_pkg::NOTE_W-1:0]   note_map [pemn_pkg::NUM_PADS];
  logic [pemn_pkg::PAD_W-1:0]    scan_pad;
  logic in_xfer;
  logic out_free;
  logic emit;
  logic scan_done;
  logic group_end;
  logic last_now;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != pemn_pkg::S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign acc_next  = acc | pkt[pemn_pkg::NUM_PADS-1:0];
  assign group_end = (packet_counter >= group_size);
  assign emit      = (state == pemn_pkg::S_SCAN) && chg[scan_pad] && out_free;
  assign scan_done = (state == pemn_pkg::S_SCAN) && (!chg[scan_pad] || emit) &&
                     (scan_pad == pemn_pkg::PAD_W'(pemn_pkg::NUM_PADS - 1));
  assign last_now  = ((chg & ~(pemn_pkg::NUM_PADS'(1) << scan_pad)) == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= pemn_pkg::S_IDLE;
      byte_left      <= '0;
      acc            <= '0;
      held           <= '1;
      chg            <= '0;
      packet_counter <= '0;
      scan_pad       <= '0;
      out_valid      <= 1'b0;
      group_size     <= '0;
      for (int i = 0; i < pemn_pkg::NUM_PADS; i++) begin
        note_map[i] <= pemn_pkg::NOTE_BASE + pemn_pkg::NOTE_W'(i);
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < pemn_pkg::REG_GROUP_SIZE) begin
          note_map[cfg_index] <= cfg_data[pemn_pkg::NOTE_W-1:0];
        end else if (cfg_index == pemn_pkg::REG_GROUP_SIZE) begin
          group_size <= cfg_data[pemn_pkg::GROUP_W-1:0];
        end
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        pemn_pkg::S_IDLE: begin
          if (in_xfer) begin
            byte_left <= pemn_pkg::BYTE_W'(pemn_pkg::PACKET_BYTES - 1);
            state     <= pemn_pkg::S_GATHER;
          end
        end
        pemn_pkg::S_GATHER: begin
          byte_left <= byte_left - 1'b1;
          if (byte_left != '0) begin
            acc <= acc_next;
          end else if (!group_end) begin
            acc            <= acc_next;
            packet_counter <= packet_counter + 1'b1;
            state          <= pemn_pkg::S_IDLE;
          end else begin
            acc            <= '0;
            packet_counter <= '0;
            chg            <= acc_next ^ held;
            held           <= acc_next;
            scan_pad       <= '0;
            state          <= pemn_pkg::S_SCAN;
          end
        end
        pemn_pkg::S_SCAN: begin
          if (emit) begin
            chg[scan_pad] <= 1'b0;
          end
          if (scan_done) begin
            state <= pemn_pkg::S_IDLE;
          end else if (!chg[scan_pad] || emit) begin
            scan_pad <= scan_pad + 1'b1;
          end
        end
        default: begin
          state <= pemn_pkg::S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pkt <= packet;
    end else if (state == pemn_pkg::S_GATHER) begin
      pkt <= pkt >> 8;
    end
    if (state == pemn_pkg::S_GATHER && byte_left == '0) begin
      pads <= acc_next;
    end
    if (emit) begin
      status_byte <= pads[scan_pad] ? pemn_pkg::ST_ON : pemn_pkg::ST_OFF;
      velocity    <= pads[scan_pad] ? pemn_pkg::VEL_ON : pemn_pkg::VEL_OFF;
      note        <= note_map[scan_pad];
      pad_index   <= scan_pad;
      last_event  <= last_now;
    end
  end

`ifndef ASSERT_OFF
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == pemn_pkg::S_SCAN |-> scan_pad < pemn_pkg::PAD_W'(pemn_pkg::NUM_PADS))
    else $error("scan pad out of range");

  a_scan_clears: assert property (@(posedge clk) disable iff (rst)
    scan_done |=> chg == '0)
    else $error("pending pad change left after scan");

  a_held_stable: assert property (@(posedge clk) disable iff (rst)
    state != pemn_pkg::S_GATHER |=> $stable(held))
    else $error("pad state changed outside group end");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pad_index))
    else $error("pending event overwritten");

  a_vel_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status_byte == pemn_pkg::ST_ON) == (velocity == pemn_pkg::VEL_ON))
    else $error("status and velocity disagree");
`endif

endmodule
